@@ rtl/core/preemptive_priority_scheduler_core_assert.svh @@
// Assertion macros for the preemptive priority scheduler core.
// Included by the top level; no other dependencies.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pps_pkg.sv @@
// Package for the preemptive priority scheduler core: item types, codes, constants.
// No dependencies; used by pps_cell and the top level.
package pps_pkg;

  localparam int unsigned MaxJobsDefault = 16;
  localparam int unsigned TimeW          = 32;
  localparam int unsigned ArrW           = 16;
  localparam int unsigned BurstW         = 16;
  localparam int unsigned PriW           = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ST_LOADED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;
  localparam logic [1:0] ST_RAN     = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [ArrW-1:0]   arrival_time;
    logic [BurstW-1:0] burst_time;
    logic [PriW-1:0]   priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       slot_index;
    logic             finished;
    logic [TimeW-1:0] completion_time;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
  } res_t;

  // Best candidate handed from cell to cell during a scan.
  typedef struct packed {
    logic              found;
    logic [PriW-1:0]   priority_val;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] remaining;
    logic [BurstW-1:0] burst;
  } cand_t;

  // Write command broadcast to the cells.
  typedef struct packed {
    logic              load;
    logic              update;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
    logic [PriW-1:0]   priority_val;
    logic [BurstW-1:0] remaining;
  } wr_t;

endpackage

@@ rtl/core/preemptive_priority_scheduler_core.sv @@
// Preemptive priority scheduler core: a row of MaxJobs job cells with a control sequencer.
// Load item: result strobe in the cycle after acceptance; the block stays idle, so the
// next item can be accepted at once. Tick item: the best candidate walks the cell row
// one cell per cycle in SCAN, then DONE and FIN; busy holds off new items throughout.
// The receiver cannot stall: every result is shown for one cycle. Reset clears the job
// count, the time counter and the sequencer; slot contents stay undefined until loaded.
`include "preemptive_priority_scheduler_core_assert.svh"

module preemptive_priority_scheduler_core import pps_pkg::*; #(
  parameter int unsigned MaxJobs = MaxJobsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_strobe_o,
  output res_t res_o
);

  localparam int unsigned IdxW = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int unsigned CntW = $clog2(MaxJobs + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  scan_cnt_q, scan_cnt_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [TimeW-1:0] time_q, time_d;
  logic             strobe_q, strobe_d;
  res_t             res_q, res_d;

  logic [TimeW-1:0] time_nx_q;
  cand_t            win_q;
  logic [IdxW-1:0]  win_slot_q;
  logic [TimeW-1:0] tat_q;

  wr_t              wr;
  logic [IdxW-1:0]  wr_slot;
  logic             accept;

  cand_t           cand_chain [MaxJobs+1];
  logic [IdxW-1:0] slot_chain [MaxJobs+1];

  logic [CntW+3:0]  count_ext;
  logic [IdxW+3:0]  slot_ext;
  logic [TimeW-1:0] burst_ext;

  assign cand_chain[0] = '0;
  assign slot_chain[0] = '0;

  for (genvar g = 0; g < MaxJobs; g++) begin : g_cell
    pps_cell #(
      .CntW (CntW),
      .IdxW (IdxW),
      .Index(g)
    ) u_cell (
      .clk_i    (clk_i),
      .count_i  (count_q),
      .time_i   (time_q),
      .wr_i     (wr),
      .wr_slot_i(wr_slot),
      .cand_i   (cand_chain[g]),
      .slot_i   (slot_chain[g]),
      .cand_o   (cand_chain[g+1]),
      .slot_o   (slot_chain[g+1])
    );
  end

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign count_ext = {4'b0, count_q};
  assign slot_ext  = {4'b0, win_slot_q};
  assign burst_ext = {{(TimeW-BurstW){1'b0}}, win_q.burst};

  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    count_d    = count_q;
    time_d     = time_q;
    strobe_d   = 1'b0;
    res_d      = res_q;
    wr         = '0;
    wr_slot    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.opcode == OP_LOAD) begin
            strobe_d = 1'b1;
            res_d    = '0;
            if (count_q == CntW'(MaxJobs)) begin
              res_d.status = ST_DROPPED;
            end else begin
              res_d.status     = ST_LOADED;
              res_d.slot_index = count_ext[3:0];
              wr.load          = 1'b1;
              wr.arrival       = req_i.arrival_time;
              wr.burst         = req_i.burst_time;
              wr.priority_val  = req_i.priority_req;
              wr.remaining     = req_i.burst_time;
              wr_slot          = count_q[IdxW-1:0];
              count_d          = count_q + 1'b1;
            end
          end else begin
            state_d    = S_SCAN;
            scan_cnt_d = '0;
          end
        end
      end
      S_SCAN: begin
        // Hold until the candidate has passed the last cell.
        scan_cnt_d = scan_cnt_q + 1'b1;
        if (scan_cnt_q == IdxW'(MaxJobs - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_FIN;
        time_d  = time_nx_q;
        if (cand_chain[MaxJobs].found) begin
          wr.update    = 1'b1;
          wr.remaining = cand_chain[MaxJobs].remaining - 1'b1;
          wr_slot      = slot_chain[MaxJobs];
        end
      end
      S_FIN: begin
        state_d  = S_IDLE;
        strobe_d = 1'b1;
        res_d    = '0;
        if (win_q.found) begin
          res_d.status     = ST_RAN;
          res_d.slot_index = slot_ext[3:0];
          if (win_q.remaining == BurstW'(1)) begin
            res_d.finished        = 1'b1;
            res_d.completion_time = time_q;
            res_d.turnaround      = tat_q;
            res_d.waiting         = (tat_q >= burst_ext) ? (tat_q - burst_ext) : '0;
          end
        end else begin
          res_d.status = ST_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_cnt_q <= '0;
      count_q    <= '0;
      time_q     <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      count_q    <= count_d;
      time_q     <= time_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept && (req_i.opcode == OP_TICK)) begin
      // Saturate the clock at its maximum.
      time_nx_q <= (time_q == '1) ? time_q : time_q + 1'b1;
    end
    if (state_q == S_DONE) begin
      win_q      <= cand_chain[MaxJobs];
      win_slot_q <= slot_chain[MaxJobs];
      tat_q      <= time_nx_q - {{(TimeW-ArrW){1'b0}}, cand_chain[MaxJobs].arrival};
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  `PPS_ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, accept && (req_i.opcode == OP_TICK), busy && (state_q == S_SCAN), "tick item did not start a scan")
  `PPS_ASSERT_NEXT(a_load_result, clk_i, rst_ni, accept && (req_i.opcode == OP_LOAD), res_strobe_o && !busy, "load item gave no result in the next cycle")
  `PPS_ASSERT_NOW(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CntW'(MaxJobs), "job count beyond table size")
  `PPS_ASSERT_NOW(a_finish_ran, clk_i, rst_ni, res_strobe_o && res_o.finished, res_o.status == ST_RAN, "completion reported without a job run")

endmodule

@@ rtl/core/pps_cell.sv @@
// One job slot of the scheduler chain: holds the job entry and compares it
// against the candidate from its left neighbor. Depends on pps_pkg.
module pps_cell import pps_pkg::*; #(
  parameter int unsigned CntW  = 5,
  parameter int unsigned IdxW  = 4,
  parameter int unsigned Index = 0
) (
  input  logic             clk_i,
  input  logic [CntW-1:0]  count_i,
  input  logic [TimeW-1:0] time_i,
  input  wr_t              wr_i,
  input  logic [IdxW-1:0]  wr_slot_i,
  input  cand_t            cand_i,
  input  logic [IdxW-1:0]  slot_i,
  output cand_t            cand_o,
  output logic [IdxW-1:0]  slot_o
);

  logic [ArrW-1:0]   arr_q;
  logic [BurstW-1:0] bur_q;
  logic [BurstW-1:0] rem_q;
  logic [PriW-1:0]   pri_q;
  cand_t             cand_q;
  logic [IdxW-1:0]   slot_q;

  logic sel_me;
  logic eligible;
  logic better;

  assign sel_me   = (wr_slot_i == IdxW'(Index));
  assign eligible = (CntW'(Index) < count_i) &&
                    ({{(TimeW-ArrW){1'b0}}, arr_q} <= time_i) && (rem_q != '0);
  // Earlier cells win ties, so only a strictly better entry replaces the candidate.
  assign better   = !cand_i.found || (pri_q < cand_i.priority_val) ||
                    ((pri_q == cand_i.priority_val) && (arr_q < cand_i.arrival));

  always_ff @(posedge clk_i) begin
    if (sel_me && wr_i.load) begin
      arr_q <= wr_i.arrival;
      bur_q <= wr_i.burst;
      pri_q <= wr_i.priority_val;
    end
    if (sel_me && (wr_i.load || wr_i.update)) begin
      rem_q <= wr_i.remaining;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eligible && better) begin
      cand_q <= '{found: 1'b1, priority_val: pri_q, arrival: arr_q,
                  remaining: rem_q, burst: bur_q};
      slot_q <= IdxW'(Index);
    end else begin
      cand_q <= cand_i;
      slot_q <= slot_i;
    end
  end

  assign cand_o = cand_q;
  assign slot_o = slot_q;

endmodule

@@ tb/tb_preemptive_priority_scheduler_core.sv @@
// Self-checking testbench for preemptive_priority_scheduler_core: directed and random
// load/tick items, checked against a scheduler model kept in the testbench.
// Depends on pps_pkg and the core RTL only.
module tb_preemptive_priority_scheduler_core;
  import pps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = MaxJobsDefault + 8;
  localparam int unsigned RandomItems   = 1500;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_strobe_o;
  res_t res_o;

  // Scheduler state mirrored by the testbench.
  logic [ArrW-1:0]   job_arrival [MaxJobsDefault];
  logic [BurstW-1:0] job_burst   [MaxJobsDefault];
  logic [BurstW-1:0] job_left    [MaxJobsDefault];
  logic [PriW-1:0]   job_prio    [MaxJobsDefault];
  int unsigned       jobs_loaded = 0;
  logic [TimeW-1:0]  sched_now   = '0;

  res_t        pending_results [$];
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle     = 1'b0;

  preemptive_priority_scheduler_core i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .res_strobe_o,
    .res_o
  );

  always #1ns clk_i = ~clk_i;

  // Compute the result of one item and update the mirrored table and time.
  function automatic res_t schedule_item(input req_t it);
    res_t             r;
    int               best;
    logic [TimeW-1:0] arr32;
    logic [TimeW-1:0] bur32;
    logic [TimeW-1:0] tat;
    r = '0;
    best = -1;
    if (it.opcode == OP_LOAD) begin
      if (jobs_loaded >= MaxJobsDefault) begin
        r.status = ST_DROPPED;
      end else begin
        job_arrival[jobs_loaded] = it.arrival_time;
        job_burst[jobs_loaded]   = it.burst_time;
        job_left[jobs_loaded]    = it.burst_time;
        job_prio[jobs_loaded]    = it.priority_req;
        r.status     = ST_LOADED;
        r.slot_index = 4'(jobs_loaded);
        jobs_loaded++;
      end
      return r;
    end
    for (int i = 0; i < int'(jobs_loaded); i++) begin
      arr32 = {{(TimeW-ArrW){1'b0}}, job_arrival[i]};
      if (arr32 <= sched_now && job_left[i] != '0) begin
        if (best < 0 || job_prio[i] < job_prio[best] ||
            (job_prio[i] == job_prio[best] && job_arrival[i] < job_arrival[best])) begin
          best = i;
        end
      end
    end
    if (sched_now != '1) sched_now++;
    if (best < 0) begin
      r.status = ST_IDLE;
      return r;
    end
    job_left[best]--;
    r.status     = ST_RAN;
    r.slot_index = 4'(best);
    if (job_left[best] == '0) begin
      arr32 = {{(TimeW-ArrW){1'b0}}, job_arrival[best]};
      bur32 = {{(TimeW-BurstW){1'b0}}, job_burst[best]};
      tat   = sched_now - arr32;
      r.finished        = 1'b1;
      r.completion_time = sched_now;
      r.turnaround      = tat;
      // Clamp at zero once the time counter has saturated.
      r.waiting         = (tat >= bur32) ? tat - bur32 : '0;
    end
    return r;
  endfunction

  function automatic string fmt_res(input res_t r);
    return $sformatf("st=%0d slot=%0d fin=%0d ct=%0d tat=%0d wt=%0d", r.status,
                     r.slot_index, r.finished, r.completion_time, r.turnaround, r.waiting);
  endfunction

  task automatic note_failure(input string what, input res_t want, input res_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected %s, got %s", $realtime, what, fmt_res(want), fmt_res(got));
    end
  endtask

  // Send one item after a random gap; start stays high when the next item follows at once.
  task automatic send_item(input req_t it);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(schedule_item(it));
  endtask

  task automatic send_load(input logic [ArrW-1:0] arr, input logic [BurstW-1:0] bur,
                           input logic [PriW-1:0] prio);
    req_t it;
    it.opcode       = OP_LOAD;
    it.arrival_time = arr;
    it.burst_time   = bur;
    it.priority_req = prio;
    send_item(it);
  endtask

  // Ticks carry random content in the fields the block ignores.
  task automatic send_tick();
    req_t it;
    it = req_t'({$urandom, $urandom});
    it.opcode = OP_TICK;
    send_item(it);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic wait_for_results();
    if (pending_results.size() != 0) begin
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic test_idle_tick();
    req_t it;
    it = '0;
    it.opcode = OP_TICK;
    send_item(it);
    it = '1;
    send_item(it);
  endtask

  task automatic test_priority_order();
    send_load(16'd0, 16'd3, 8'd10);
    // Arrives later with a better priority: preempts slot 0.
    send_load(16'd4, 16'd2, 8'd5);
    // No work left from the start: never chosen.
    send_load(16'd0, 16'd0, 8'd0);
    // Never arrives within the run.
    send_load(16'hFFFF, 16'hFFFF, 8'd0);
    // Same priority as slot 0 but later; the next one also ties on arrival.
    send_load(16'd1, 16'd2, 8'd10);
    send_load(16'd1, 16'd1, 8'd10);
    send_load(16'd2, 16'd1, 8'd255);
    repeat (12) send_tick();
  endtask

  task automatic test_random_traffic();
    req_t             it;
    int unsigned      r;
    logic [TimeW-1:0] arr;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) begin
        wait_for_results();
        no_idle = ((n / 100) % 4 == 3);
      end
      r = $urandom_range(0, 99);
      if (jobs_loaded < MaxJobsDefault && r < 5) begin
        // Arrival mostly just ahead of the current time, sometimes in the past.
        if ($urandom_range(0, 4) == 0) arr = $urandom_range(0, sched_now);
        else arr = sched_now + $urandom_range(0, 30);
        send_load(ArrW'(arr), BurstW'($urandom_range(1, 40)), PriW'($urandom_range(0, 255)));
      end else if (jobs_loaded >= MaxJobsDefault && r < 20) begin
        it = req_t'({$urandom, $urandom});
        it.opcode = OP_LOAD;
        send_item(it);
      end else begin
        send_tick();
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_table_full();
    req_t it;
    while (jobs_loaded < MaxJobsDefault) begin
      send_load(ArrW'(sched_now), BurstW'($urandom_range(1, 8)), PriW'($urandom_range(0, 255)));
    end
    it = '0;
    it.opcode = OP_LOAD;
    send_item(it);
    it = '1;
    it.opcode = OP_LOAD;
    send_item(it);
    repeat (4) send_tick();
  endtask

  // Compare each result with the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_strobe_o) begin
      if (pending_results.size() == 0) begin
        note_failure("result with nothing outstanding", '0, res_o);
      end else begin
        want = pending_results.pop_front();
        if (res_o.status !== want.status || res_o.slot_index !== want.slot_index ||
            res_o.finished !== want.finished ||
            res_o.completion_time !== want.completion_time ||
            res_o.turnaround !== want.turnaround || res_o.waiting !== want.waiting) begin
          note_failure("result mismatch", want, res_o);
        end
      end
    end
  end

  // End the run when nothing is accepted or returned for too long.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((start && !busy) || res_strobe_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_tick();
    test_priority_order();
    wait_for_results();
    test_random_traffic();
    test_table_full();

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
